// ----- hw/rtl/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared types, constants and match tables for the http request header parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int LENGTH_WIDTH_DEF = 32;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_PATH = 2'd1;
  localparam logic [1:0] CAP_HOST = 2'd2;

  localparam logic [1:0] METHOD_NONE = 2'd0;
  localparam logic [1:0] PROTO_NONE  = 2'd0;

  localparam int PFX_NUM = 4;
  localparam int VER_NUM = 3;

  localparam logic [1:0] PFX_GET    = 2'd0;
  localparam logic [1:0] PFX_POST   = 2'd1;
  localparam logic [1:0] PFX_HOST   = 2'd2;
  localparam logic [1:0] PFX_LENGTH = 2'd3;

  // "GET ", "POST ", "Host: ", "Content-Length: "
  localparam logic [7:0] PFX_TEXT [PFX_NUM][16] = '{
    '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h6F, 8'h73, 8'h74, 8'h3A, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20}
  };
  localparam logic [4:0] PFX_LEN [PFX_NUM] = '{5'd4, 5'd5, 5'd6, 5'd16};

  // "HTTP/1.0", "HTTP/1.1", "HTTP/2"
  localparam logic [7:0] VER_TEXT [VER_NUM][8] = '{
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h32, 8'h00, 8'h00}
  };
  localparam logic [3:0] VER_LEN [VER_NUM] = '{4'd8, 4'd8, 4'd6};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       header_end;
  } item_t;

  typedef struct packed {
    logic [1:0]  capture_kind;
    logic [7:0]  capture_byte;
    logic        header_done;
    logic [1:0]  method_code;
    logic [1:0]  protocol_code;
    logic [31:0] body_length;
    logic        length_seen;
    logic        host_seen;
  } result_t;

endpackage

// ----- hw/rtl/hrhp_in_stage.sv -----
// ----------------------------------------------------------------------------
// hrhp_in_stage
// input register holding one header byte until the parse stage takes it
// ----------------------------------------------------------------------------
module hrhp_in_stage
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_header_end,
  input  logic       take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.in_byte    <= in_byte;
      item_r.header_end <= in_header_end;
    end
  end

endmodule

// ----- hw/rtl/hrhp_parse.sv -----
// ----------------------------------------------------------------------------
// hrhp_parse
// per-byte line state: prefix match, path/host capture, version match and
// content length accumulation, with the header summary on the last byte
// ----------------------------------------------------------------------------
module hrhp_parse
  import hrhp_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  localparam int LW = LENGTH_WIDTH;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_PATH,
    PH_VERSION,
    PH_HOST,
    PH_LENGTH,
    PH_IGNORE
  } phase_t;

  logic [4:0]    pos_r, pos_nxt;
  logic [3:0]    alive_r, alive_nxt;
  phase_t        phase_r, phase_nxt;
  logic [2:0]    ver_alive_r, ver_alive_nxt;
  logic [3:0]    ver_pos_r, ver_pos_nxt;
  logic [LW-1:0] acc_r, acc_nxt;
  logic [1:0]    method_r, method_nxt;
  logic [1:0]    proto_r, proto_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [1:0]    seen_r, seen_nxt;
  logic          after_cr_r, after_cr_nxt;

  logic [7:0]    b;
  logic          skip_lf;
  logic          eol;
  logic          done_hit;
  logic [1:0]    done_idx;
  logic [3:0]    digit;
  logic [LW+3:0] acc_wide;
  logic [1:0]    kind;
  logic [LW+31:0] len_ext;

  always_comb begin
    b        = item.in_byte;
    skip_lf  = after_cr_r && (b == CHAR_LF);
    eol      = !skip_lf && (b == CHAR_CR);
    done_hit = 1'b0;
    done_idx = PFX_GET;
    digit    = 4'(b - DIGIT_ZERO);
    acc_wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (LW+4)'(digit);
    kind     = CAP_NONE;

    pos_nxt       = pos_r;
    alive_nxt     = alive_r;
    phase_nxt     = phase_r;
    ver_alive_nxt = ver_alive_r;
    ver_pos_nxt   = ver_pos_r;
    acc_nxt       = acc_r;
    method_nxt    = method_r;
    proto_nxt     = proto_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    after_cr_nxt  = eol;

    if (!skip_lf && !eol) begin
      case (phase_r)
        PH_PREFIX: begin
          for (int p = 0; p < PFX_NUM; p++) begin
            if (alive_r[p]) begin
              if ((pos_r < PFX_LEN[p]) && (PFX_TEXT[p][pos_r[3:0]] == b)) begin
                if (pos_r == PFX_LEN[p] - 5'd1) begin
                  done_hit = 1'b1;
                  done_idx = 2'(p);
                end
              end else begin
                alive_nxt[p] = 1'b0;
              end
            end
          end
          if (done_hit) begin
            case (done_idx)
              PFX_GET, PFX_POST: begin
                phase_nxt  = PH_PATH;
                method_nxt = done_idx + 2'd1;
              end
              PFX_HOST:   phase_nxt = PH_HOST;
              PFX_LENGTH: phase_nxt = PH_LENGTH;
              default:    phase_nxt = PH_IGNORE;
            endcase
          end else if (alive_nxt == 4'b0000) begin
            phase_nxt = PH_IGNORE;
          end
          if (pos_r != 5'd31) begin
            pos_nxt = pos_r + 5'd1;
          end
        end
        PH_PATH: begin
          if (b == CHAR_SP) begin
            phase_nxt = PH_VERSION;
          end else begin
            kind = CAP_PATH;
          end
        end
        PH_VERSION: begin
          for (int v = 0; v < VER_NUM; v++) begin
            if (ver_alive_r[v] && ((ver_pos_r >= VER_LEN[v]) ||
                (VER_TEXT[v][ver_pos_r[2:0]] != b))) begin
              ver_alive_nxt[v] = 1'b0;
            end
          end
          if (ver_pos_r != 4'd15) begin
            ver_pos_nxt = ver_pos_r + 4'd1;
          end
        end
        PH_HOST: kind = CAP_HOST;
        PH_LENGTH: begin
          if ((b >= DIGIT_ZERO) && (b <= DIGIT_NINE)) begin
            if (|acc_wide[LW+3:LW]) begin
              acc_nxt = '1;
            end else begin
              acc_nxt = acc_wide[LW-1:0];
            end
          end
        end
        default: ;
      endcase
    end

    // line end: commit what the line carried, then start a fresh line
    if (eol || item.header_end) begin
      case (phase_nxt)
        PH_VERSION: begin
          for (int v = 0; v < VER_NUM; v++) begin
            if (ver_alive_nxt[v] && (ver_pos_nxt == VER_LEN[v])) begin
              proto_nxt = 2'(v + 1);
            end
          end
        end
        PH_LENGTH: begin
          len_nxt     = acc_nxt;
          seen_nxt[0] = 1'b1;
        end
        PH_HOST: seen_nxt[1] = 1'b1;
        default: ;
      endcase
      pos_nxt       = '0;
      alive_nxt     = '1;
      phase_nxt     = PH_PREFIX;
      ver_alive_nxt = '1;
      ver_pos_nxt   = '0;
      acc_nxt       = '0;
    end

    len_ext = {32'b0, len_nxt};

    result.capture_kind  = kind;
    result.capture_byte  = (kind != CAP_NONE) ? b : 8'h00;
    result.header_done   = item.header_end;
    result.method_code   = item.header_end ? method_nxt : METHOD_NONE;
    result.protocol_code = item.header_end ? proto_nxt : PROTO_NONE;
    result.body_length   = !item.header_end ? 32'h0 :
                           (|len_ext[LW+31:32]) ? 32'hFFFF_FFFF : len_ext[31:0];
    result.length_seen   = item.header_end && seen_nxt[0];
    result.host_seen     = item.header_end && seen_nxt[1];

    // summary reported, header state back to reset
    if (item.header_end) begin
      method_nxt   = METHOD_NONE;
      proto_nxt    = PROTO_NONE;
      len_nxt      = '0;
      seen_nxt     = '0;
      after_cr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      alive_r     <= '1;
      phase_r     <= PH_PREFIX;
      ver_alive_r <= '1;
      ver_pos_r   <= '0;
      acc_r       <= '0;
      method_r    <= METHOD_NONE;
      proto_r     <= PROTO_NONE;
      len_r       <= '0;
      seen_r      <= '0;
      after_cr_r  <= 1'b0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      alive_r     <= alive_nxt;
      phase_r     <= phase_nxt;
      ver_alive_r <= ver_alive_nxt;
      ver_pos_r   <= ver_pos_nxt;
      acc_r       <= acc_nxt;
      method_r    <= method_nxt;
      proto_r     <= proto_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      after_cr_r  <= after_cr_nxt;
    end
  end

endmodule

// ----- hw/rtl/hrhp_out_stage.sv -----
// ----------------------------------------------------------------------------
// hrhp_out_stage
// result register feeding the output channel
// ----------------------------------------------------------------------------
module hrhp_out_stage
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  result_t     result,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_capture_kind,
  output logic [7:0]  out_capture_byte,
  output logic        out_header_done,
  output logic [1:0]  out_method_code,
  output logic [1:0]  out_protocol_code,
  output logic [31:0] out_body_length,
  output logic        out_length_seen,
  output logic        out_host_seen
);

  logic    valid_r;
  result_t res_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_capture_kind  = res_r.capture_kind;
  assign out_capture_byte  = res_r.capture_byte;
  assign out_header_done   = res_r.header_done;
  assign out_method_code   = res_r.method_code;
  assign out_protocol_code = res_r.protocol_code;
  assign out_body_length   = res_r.body_length;
  assign out_length_seen   = res_r.length_seen;
  assign out_host_seen     = res_r.host_seen;

endmodule

// ----- hw/rtl/http_request_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// http_request_header_parser_core
// parses an http request header one byte per transfer: path and host capture
// per byte, method, protocol and content length summary on the last byte
// ----------------------------------------------------------------------------
// channel  | direction | handshake           | payload
// in       | input     | in_valid / in_stall | in_byte, in_header_end
// out      | output    | out_valid/out_stall | capture, header summary
//
// one byte per cycle while out_stall is low; each input transfer gives exactly one output transfer
// each byte passes through the input register, then the result register
// reset is synchronous on rst_n and returns all line and header state to idle
// in_stall rises only while both registers are full and out_stall is high
// ----------------------------------------------------------------------------
module http_request_header_parser_core
  import hrhp_pkg::*;
#(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_header_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_capture_kind,
  output logic [7:0]  out_capture_byte,
  output logic        out_header_done,
  output logic [1:0]  out_method_code,
  output logic [1:0]  out_protocol_code,
  output logic [31:0] out_body_length,
  output logic        out_length_seen,
  output logic        out_host_seen
);

  logic    ready;
  logic    item_valid;
  item_t   item;
  logic    fire;
  result_t result;

  assign fire = item_valid && ready;

  hrhp_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_header_end (in_header_end),
    .take          (ready),
    .item_valid    (item_valid),
    .item          (item)
  );

  hrhp_parse #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  hrhp_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire              (fire),
    .result            (result),
    .ready             (ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_capture_kind  (out_capture_kind),
    .out_capture_byte  (out_capture_byte),
    .out_header_done   (out_header_done),
    .out_method_code   (out_method_code),
    .out_protocol_code (out_protocol_code),
    .out_body_length   (out_body_length),
    .out_length_seen   (out_length_seen),
    .out_host_seen     (out_host_seen)
  );

  a_stall_from_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_capture_kind != 2'd3))
    else $error("illegal capture kind");

  a_no_capture_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_capture_kind == CAP_NONE)) |-> (out_capture_byte == 8'h00))
    else $error("capture byte set without capture");

  a_summary_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_header_done) |->
      ((out_method_code == METHOD_NONE) && (out_protocol_code == PROTO_NONE) &&
       (out_body_length == 32'h0) && !out_length_seen && !out_host_seen))
    else $error("summary fields set before header end");

endmodule
